// ----- rtl/smc_pkg.sv -----
// Package: shared types and constants for the checked SPI mode 0 master.
`timescale 1ns / 1ps

package smc_pkg;

  localparam int COUNT_BITS = 16;
  localparam int IN_BITS    = 56;
  localparam int OUT_BITS   = 16;
  localparam logic [7:0] TOP_BIT = 8'h80;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  typedef enum logic [9:0] {
    PH_IDLE   = 10'b00_0000_0001,
    PH_WLOAD  = 10'b00_0000_0010,
    PH_WMOSI  = 10'b00_0000_0100,
    PH_WSCKH  = 10'b00_0000_1000,
    PH_WSCKL  = 10'b00_0001_0000,
    PH_RSCKH  = 10'b00_0010_0000,
    PH_RSCKL  = 10'b00_0100_0000,
    PH_REND   = 10'b00_1000_0000,
    PH_CSUP   = 10'b01_0000_0000,
    PH_FINISH = 10'b10_0000_0000
  } phase_t;

  typedef enum logic [1:0] {
    CHK_NONE = 2'd0,
    CHK_CS   = 2'd1,
    CHK_SCK  = 2'd2,
    CHK_MOSI = 2'd3
  } chk_t;

  typedef struct packed {
    logic        mosi_level;
    logic        sck_level;
    logic        cs_level;
    logic        miso;
    logic [7:0]  write_byte;
    logic [15:0] read_count;
    logic [15:0] write_count;
    logic [7:0]  opcode;
    logic        start_req;
  } in_item_t;

  typedef struct packed {
    logic       ok;
    logic       done_res;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       take_write_byte;
    logic       mosi;
    logic       sck;
    logic       cs;
  } res_t;

endpackage

// ----- rtl/smc_core.sv -----
// Transaction state and single-pass per-word update of the SPI master.
`timescale 1ns / 1ps

module smc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  smc_pkg::in_item_t item,
  output smc_pkg::res_t     res
);
  import smc_pkg::*;

  phase_t     phase, phase_next;
  logic [2:0] bit_index, bit_index_next;
  logic [7:0] shift_reg, shift_reg_next;
  cnt_t       writes_left, writes_left_next;
  cnt_t       reads_left, reads_left_next;
  logic       status_ok, status_ok_next;
  logic       cs_drv, cs_drv_next;
  logic       sck_drv, sck_drv_next;
  logic       mosi_drv, mosi_drv_next;
  chk_t       chk, chk_next;

  logic       fail;
  logic       run;
  phase_t     ph_sel;
  logic       take;
  logic [7:0] rbyte;
  logic       rvalid;
  logic       done;

  always_comb begin
    phase_next       = phase;
    bit_index_next   = bit_index;
    shift_reg_next   = shift_reg;
    writes_left_next = writes_left;
    reads_left_next  = reads_left;
    status_ok_next   = status_ok;
    cs_drv_next      = cs_drv;
    sck_drv_next     = sck_drv;
    mosi_drv_next    = mosi_drv;
    chk_next         = chk;
    take             = 1'b0;
    rbyte            = 8'd0;
    rvalid           = 1'b0;
    done             = 1'b0;
    run              = 1'b1;
    ph_sel           = phase;

    case (chk)
      CHK_CS:   fail = item.cs_level != cs_drv;
      CHK_SCK:  fail = item.sck_level != sck_drv;
      CHK_MOSI: fail = item.mosi_level != mosi_drv;
      default:  fail = 1'b0;
    endcase

    // readback mismatch: abort, bring SCK low first if it is high
    if (fail) begin
      status_ok_next = 1'b0;
      if (phase != PH_FINISH) begin
        ph_sel = PH_CSUP;
        if (sck_drv) begin
          sck_drv_next = 1'b0;
          chk_next     = CHK_SCK;
          phase_next   = PH_CSUP;
          run          = 1'b0;
        end
      end
    end

    if (run) begin
      unique case (ph_sel)
        PH_IDLE: begin
          if (item.start_req) begin
            shift_reg_next   = item.opcode;
            writes_left_next = COUNT_BITS'(item.write_count);
            reads_left_next  = COUNT_BITS'(item.read_count);
            status_ok_next   = 1'b1;
            bit_index_next   = 3'd0;
            cs_drv_next      = 1'b0;
            chk_next         = CHK_CS;
            phase_next       = PH_WMOSI;
          end else begin
            chk_next   = CHK_NONE;
            phase_next = PH_IDLE;
          end
        end
        PH_WLOAD: begin
          shift_reg_next   = item.write_byte;
          take             = 1'b1;
          writes_left_next = writes_left - cnt_t'(1);
          bit_index_next   = 3'd0;
          mosi_drv_next    = |(item.write_byte & TOP_BIT);
          chk_next         = CHK_MOSI;
          phase_next       = PH_WSCKH;
        end
        PH_WMOSI: begin
          mosi_drv_next = shift_reg[~bit_index];
          chk_next      = CHK_MOSI;
          phase_next    = PH_WSCKH;
        end
        PH_WSCKH: begin
          sck_drv_next = 1'b1;
          chk_next     = CHK_SCK;
          phase_next   = PH_WSCKL;
        end
        PH_WSCKL: begin
          sck_drv_next = 1'b0;
          chk_next     = CHK_SCK;
          if (bit_index == 3'd7) begin
            bit_index_next = 3'd0;
            if (writes_left != '0) begin
              phase_next = PH_WLOAD;
            end else if (reads_left != '0) begin
              phase_next = PH_RSCKH;
            end else begin
              phase_next = PH_CSUP;
            end
          end else begin
            bit_index_next = bit_index + 3'd1;
            phase_next     = PH_WMOSI;
          end
        end
        PH_RSCKH: begin
          if (bit_index == 3'd0) begin
            shift_reg_next = 8'd0;
          end
          sck_drv_next = 1'b1;
          chk_next     = CHK_SCK;
          phase_next   = PH_RSCKL;
        end
        PH_RSCKL: begin
          shift_reg_next[~bit_index] = shift_reg[~bit_index] | item.miso;
          sck_drv_next = 1'b0;
          chk_next     = CHK_SCK;
          if (bit_index == 3'd7) begin
            bit_index_next = 3'd0;
            phase_next     = PH_REND;
          end else begin
            bit_index_next = bit_index + 3'd1;
            phase_next     = PH_RSCKH;
          end
        end
        PH_REND: begin
          // deliver, then start the next byte or raise CS in the same word
          rbyte           = shift_reg;
          rvalid          = 1'b1;
          reads_left_next = reads_left - cnt_t'(1);
          if (reads_left_next != '0) begin
            shift_reg_next = 8'd0;
            sck_drv_next   = 1'b1;
            chk_next       = CHK_SCK;
            phase_next     = PH_RSCKL;
          end else begin
            cs_drv_next = 1'b1;
            chk_next    = CHK_CS;
            phase_next  = PH_FINISH;
          end
        end
        PH_CSUP: begin
          cs_drv_next = 1'b1;
          chk_next    = CHK_CS;
          phase_next  = PH_FINISH;
        end
        PH_FINISH: begin
          done       = 1'b1;
          chk_next   = CHK_NONE;
          phase_next = PH_IDLE;
        end
        default: begin
          chk_next   = CHK_NONE;
          phase_next = PH_IDLE;
        end
      endcase
    end

    res.cs              = cs_drv_next;
    res.sck             = sck_drv_next;
    res.mosi            = mosi_drv_next;
    res.take_write_byte = take;
    res.read_byte       = rbyte;
    res.read_valid      = rvalid;
    res.busy_res        = phase_next != PH_IDLE;
    res.done_res        = done;
    res.ok              = status_ok_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_index   <= 3'd0;
      shift_reg   <= 8'd0;
      writes_left <= '0;
      reads_left  <= '0;
      status_ok   <= 1'b1;
      cs_drv      <= 1'b1;
      sck_drv     <= 1'b0;
      mosi_drv    <= 1'b0;
      chk         <= CHK_NONE;
    end else if (advance) begin
      phase       <= phase_next;
      bit_index   <= bit_index_next;
      shift_reg   <= shift_reg_next;
      writes_left <= writes_left_next;
      reads_left  <= reads_left_next;
      status_ok   <= status_ok_next;
      cs_drv      <= cs_drv_next;
      sck_drv     <= sck_drv_next;
      mosi_drv    <= mosi_drv_next;
      chk         <= chk_next;
    end
  end

  a_idle_cs_high: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> cs_drv)
    else $error("chip select low while idle");

  a_sck_high_phase: assert property (@(posedge clk) disable iff (rst)
    sck_drv |-> (phase == PH_WSCKL || phase == PH_RSCKL))
    else $error("SCK high outside a clock-low phase");

  a_finish_to_idle: assert property (@(posedge clk) disable iff (rst)
    (advance && phase == PH_FINISH) |=> phase == PH_IDLE && chk == CHK_NONE)
    else $error("finish did not return to idle");

  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    res.done_res |-> (!res.busy_res && res.cs && !res.sck))
    else $error("done with pins not at rest");

  a_abort_sck: assert property (@(posedge clk) disable iff (rst)
    (advance && fail && sck_drv && phase != PH_FINISH) |=>
      (!sck_drv && chk == CHK_SCK && phase == PH_CSUP && !status_ok))
    else $error("abort with SCK high mishandled");

endmodule

// ----- rtl/spi_mode0_master_checked.sv -----
// Top level: stream ports and output register around the SPI master update.
// A result word is on m_axis_tdata in the cycle after its input word is taken.
// While results are taken, one word per cycle, each one pin tick updated in one pass.
// The output register lets a new word in while the last result waits, as long as
// it is taken in the same cycle. Synchronous active-high reset: idle, CS high,
// SCK and MOSI low, status ok, no pending pin check, output register empty.
`timescale 1ns / 1ps

module spi_mode0_master_checked (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // start_req, opcode, write_count, read_count, write_byte, miso,
  // cs_level, sck_level, mosi_level, zero pad
  input  logic [smc_pkg::IN_BITS-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // cs, sck, mosi, take_write_byte, read_byte, read_valid, busy_res, done_res, ok
  output logic [smc_pkg::OUT_BITS-1:0] m_axis_tdata
);
  import smc_pkg::*;

  in_item_t item;
  res_t     res;
  res_t     res_q;
  logic     accept;

  assign item          = s_axis_tdata[$bits(in_item_t)-1:0];
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = res_q;

  smc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .item    (item),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res;
    end
  end

endmodule

// ----- dv/spi_mode0_master_checked_test.sv -----
// Testbench for the checked SPI mode 0 master: predicted pin ticks and stream checks.
`timescale 1ns / 1ps

import smc_pkg::*;

class spi_frame_board;
  phase_t     ph;
  chk_t       chk;
  logic       drv_cs;
  logic       drv_sck;
  logic       drv_mosi;
  logic [2:0] bidx;
  logic [7:0] shreg;
  cnt_t       wleft;
  cnt_t       rleft;
  logic       status_ok;
  res_t       want_words[$];
  int unsigned mismatches;

  function new();
    ph         = PH_IDLE;
    chk        = CHK_NONE;
    drv_cs     = 1'b1;
    drv_sck    = 1'b0;
    drv_mosi   = 1'b0;
    bidx       = 3'd0;
    shreg      = 8'd0;
    wleft      = '0;
    rleft      = '0;
    status_ok  = 1'b1;
    mismatches = 0;
  endfunction

  function res_t tick_pins(in_item_t w);
    res_t r;
    logic fail;
    logic again;
    r = '0;
    again = 1'b1;
    case (chk)
      CHK_CS:   fail = (w.cs_level != drv_cs);
      CHK_SCK:  fail = (w.sck_level != drv_sck);
      CHK_MOSI: fail = (w.mosi_level != drv_mosi);
      default:  fail = 1'b0;
    endcase
    if (fail) begin
      status_ok = 1'b0;
      if (ph != PH_FINISH) begin
        ph = PH_CSUP;
        // SCK must come down before CS rises
        if (drv_sck) begin
          drv_sck = 1'b0;
          chk     = CHK_SCK;
          again   = 1'b0;
        end
      end
    end
    while (again) begin
      again = 1'b0;
      case (ph)
        PH_IDLE: begin
          if (w.start_req) begin
            shreg     = w.opcode;
            wleft     = w.write_count;
            rleft     = w.read_count;
            status_ok = 1'b1;
            bidx      = 3'd0;
            drv_cs    = 1'b0;
            chk       = CHK_CS;
            ph        = PH_WMOSI;
          end else begin
            chk = CHK_NONE;
          end
        end
        PH_WLOAD: begin
          shreg             = w.write_byte;
          r.take_write_byte = 1'b1;
          wleft             = wleft - 1'b1;
          bidx              = 3'd0;
          drv_mosi          = shreg[7];
          chk               = CHK_MOSI;
          ph                = PH_WSCKH;
        end
        PH_WMOSI: begin
          drv_mosi = ((shreg & (TOP_BIT >> bidx)) != 8'd0);
          chk      = CHK_MOSI;
          ph       = PH_WSCKH;
        end
        PH_WSCKH: begin
          drv_sck = 1'b1;
          chk     = CHK_SCK;
          ph      = PH_WSCKL;
        end
        PH_WSCKL: begin
          drv_sck = 1'b0;
          chk     = CHK_SCK;
          if (bidx == 3'd7) begin
            bidx = 3'd0;
            if (wleft != '0) ph = PH_WLOAD;
            else if (rleft != '0) ph = PH_RSCKH;
            else ph = PH_CSUP;
          end else begin
            bidx = bidx + 1'b1;
            ph   = PH_WMOSI;
          end
        end
        PH_RSCKH: begin
          if (bidx == 3'd0) shreg = 8'd0;
          drv_sck = 1'b1;
          chk     = CHK_SCK;
          ph      = PH_RSCKL;
        end
        PH_RSCKL: begin
          if (w.miso) shreg = shreg | (TOP_BIT >> bidx);
          drv_sck = 1'b0;
          chk     = CHK_SCK;
          if (bidx == 3'd7) begin
            bidx = 3'd0;
            ph   = PH_REND;
          end else begin
            bidx = bidx + 1'b1;
            ph   = PH_RSCKH;
          end
        end
        PH_REND: begin
          // byte is clean once its last fall is confirmed; next bit starts this tick
          r.read_byte  = shreg;
          r.read_valid = 1'b1;
          rleft        = rleft - 1'b1;
          ph           = (rleft != '0) ? PH_RSCKH : PH_CSUP;
          again        = 1'b1;
        end
        PH_CSUP: begin
          drv_cs = 1'b1;
          chk    = CHK_CS;
          ph     = PH_FINISH;
        end
        PH_FINISH: begin
          r.done_res = 1'b1;
          chk        = CHK_NONE;
          ph         = PH_IDLE;
        end
        default: begin
          chk = CHK_NONE;
          ph  = PH_IDLE;
        end
      endcase
    end
    r.cs       = drv_cs;
    r.sck      = drv_sck;
    r.mosi     = drv_mosi;
    r.busy_res = (ph != PH_IDLE);
    r.ok       = status_ok;
    return r;
  endfunction

  function void note_word(in_item_t w);
    want_words.push_back(tick_pins(w));
  endfunction

  function void flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %0d at %0t:%s", mismatches, $realtime, msg);
  endfunction

  function void check_word(res_t got);
    res_t  want;
    string diff;
    if (want_words.size() == 0) begin
      flag($sformatf(" output word %h with nothing expected", got));
      return;
    end
    want = want_words.pop_front();
    diff = "";
    if (got.cs != want.cs)
      diff = {diff, $sformatf(" cs %0b/%0b", want.cs, got.cs)};
    if (got.sck != want.sck)
      diff = {diff, $sformatf(" sck %0b/%0b", want.sck, got.sck)};
    if (got.mosi != want.mosi)
      diff = {diff, $sformatf(" mosi %0b/%0b", want.mosi, got.mosi)};
    if (got.take_write_byte != want.take_write_byte)
      diff = {diff, $sformatf(" take %0b/%0b", want.take_write_byte, got.take_write_byte)};
    if (got.read_byte != want.read_byte)
      diff = {diff, $sformatf(" read_byte %h/%h", want.read_byte, got.read_byte)};
    if (got.read_valid != want.read_valid)
      diff = {diff, $sformatf(" read_valid %0b/%0b", want.read_valid, got.read_valid)};
    if (got.busy_res != want.busy_res)
      diff = {diff, $sformatf(" busy %0b/%0b", want.busy_res, got.busy_res)};
    if (got.done_res != want.done_res)
      diff = {diff, $sformatf(" done %0b/%0b", want.done_res, got.done_res)};
    if (got.ok != want.ok)
      diff = {diff, $sformatf(" ok %0b/%0b", want.ok, got.ok)};
    if (diff != "") flag({" exp/got", diff});
  endfunction
endclass

module spi_mode0_master_checked_test;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // start_req, opcode, write_count, read_count, write_byte, miso,
  // cs_level, sck_level, mosi_level, zero pad
  logic [IN_BITS-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // cs, sck, mosi, take_write_byte, read_byte, read_valid, busy_res, done_res, ok
  logic [OUT_BITS-1:0] m_axis_tdata;

  spi_frame_board sb;
  int unsigned    ticks_sent = 0;

  spi_mode0_master_checked dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic cnt_t short_count();
    return ($urandom_range(9) < 8) ? cnt_t'($urandom_range(2)) : cnt_t'($urandom_range(3, 5));
  endfunction

  // one pin tick; the checked readback follows the predicted drive unless flipped
  task automatic send_tick(input logic start, input logic [7:0] op, input cnt_t wc,
                           input cnt_t rc, input logic flip);
    in_item_t w;
    logic     took;
    w.start_req   = start;
    w.opcode      = op;
    w.write_count = wc;
    w.read_count  = rc;
    w.write_byte  = 8'($urandom);
    w.miso        = 1'($urandom);
    w.cs_level    = 1'($urandom);
    w.sck_level   = 1'($urandom);
    w.mosi_level  = 1'($urandom);
    case (sb.chk)
      CHK_CS:   w.cs_level   = sb.drv_cs ^ flip;
      CHK_SCK:  w.sck_level  = sb.drv_sck ^ flip;
      CHK_MOSI: w.mosi_level = sb.drv_mosi ^ flip;
      default: ;
    endcase
    if (start || sb.ph != PH_IDLE) ticks_sent++;
    if ((ticks_sent < 500 || ticks_sent >= 700) && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_BITS'(w);
    do begin
      @(negedge clk);
      took = s_axis_tready;
      @(posedge clk);
    end while (!took);
    sb.note_word(w);
  endtask

  task automatic run_frame(input logic [7:0] op, input cnt_t wc, input cnt_t rc,
                           input int unsigned fault_pm, input bit fault_end);
    logic flip;
    send_tick(1'b1, op, wc, rc, 1'b0);
    while (sb.ph != PH_IDLE) begin
      flip = (sb.chk != CHK_NONE) &&
             (($urandom_range(999) < fault_pm) || (fault_end && sb.ph == PH_FINISH));
      send_tick(1'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), flip);
    end
  endtask

  always @(negedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_word(res_t'(m_axis_tdata));
  end

  initial begin : sink
    int unsigned rx_cyc;
    rx_cyc = 0;
    forever begin
      @(posedge clk);
      rx_cyc++;
      if (rx_cyc >= 400 && rx_cyc < 700) m_axis_tready <= 1'b0;
      else if (rx_cyc >= 900 && rx_cyc < 1200) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(99) >= 17);
    end
  end

  initial begin : stim
    int unsigned pick;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // idle words are ignored
    send_tick(1'b0, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_tick(1'b0, 8'h00, 16'h0000, 16'h0000, 1'b0);
    // opcode only
    run_frame(8'hFF, 16'h0000, 16'h0000, 0, 1'b0);
    // full-scale counts, cut short by readback faults
    run_frame(8'h00, 16'hFFFF, 16'hFFFF, 100, 1'b0);
    // write and read, bad CS readback at the end
    run_frame(8'hA5, 16'd1, 16'd1, 0, 1'b1);
    run_frame(8'h3C, 16'd0, 16'd2, 0, 1'b0);

    while (ticks_sent < 850) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        send_tick(1'b0, 8'($urandom), 16'($urandom), 16'($urandom), 1'b0);
      end else if (pick < 30) begin
        run_frame(8'($urandom), 16'($urandom), 16'($urandom), 60, 1'b0);
      end else begin
        run_frame(8'($urandom), short_count(), short_count(), (pick < 55) ? 25 : 0,
                  pick >= 95);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (sb.want_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.want_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
